@@ rtl/safg_pkg.sv @@
// Shared types, constants, microcode program and sine table builder.
`default_nettype none

package safg_pkg;

  // Default sizes
  localparam int unsigned SINE_TABLE_ENTRIES = 1024;
  localparam int unsigned COUNTER_BITS       = 17;

  // Field widths
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned PHASE_W = 17;  // phase h, 65536 = half turn
  localparam int unsigned SINE_W  = 16;  // Q1.15 sample
  localparam int unsigned CFG_W   = 16;

  // Divider: one quotient bit per step
  localparam int unsigned DIV_STEPS = PHASE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Register reset values
  localparam logic [LEVEL_W-1:0] LEVEL_MAX_RST = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN_RST = 8'd0;
  localparam logic [LEN_W-1:0]   CYCLE_LEN_RST = 16'd60;

  typedef enum logic [1:0] {
    REG_LEVEL_MAX = 2'd0,
    REG_LEVEL_MIN = 2'd1,
    REG_CYCLE_LEN = 2'd2,
    REG_FADE_MODE = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_FADE_IN  = 2'd0,
    MODE_FADE_OUT = 2'd1,
    MODE_FLASH    = 2'd2,
    MODE_FLASH_B  = 2'd3
  } fade_mode_e;

  typedef enum logic {
    ACT_ADVANCE = 1'b0,
    ACT_LOAD    = 1'b1
  } action_e;

  // Microcode
  localparam int unsigned STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    UOP_WAIT,    // take a request
    UOP_DECODE,  // update counter, set up divide
    UOP_DIV,     // one quotient bit
    UOP_INDEX,   // fold phase, form table index
    UOP_ROM,     // table read
    UOP_MUL,     // (to - from) * sine
    UOP_BLEND,   // add base, truncate
    UOP_EMIT     // load output register
  } uop_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_SKIP,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    step_t target;  // taken: jump here; else fall through to step + 1
  } ucode_t;

  localparam step_t STEP_WAIT = 3'd0;
  localparam step_t STEP_DIV  = 3'd2;
  localparam step_t STEP_EMIT = 3'd7;

  function automatic ucode_t safg_ucode(input step_t step);
    ucode_t w;
    unique case (step)
      3'd0:    w = '{op: UOP_WAIT,   cond: COND_NO_INPUT, target: STEP_WAIT};
      3'd1:    w = '{op: UOP_DECODE, cond: COND_SKIP,     target: STEP_EMIT};
      3'd2:    w = '{op: UOP_DIV,    cond: COND_DIV_MORE, target: STEP_DIV};
      3'd3:    w = '{op: UOP_INDEX,  cond: COND_NEVER,    target: STEP_WAIT};
      3'd4:    w = '{op: UOP_ROM,    cond: COND_NEVER,    target: STEP_WAIT};
      3'd5:    w = '{op: UOP_MUL,    cond: COND_NEVER,    target: STEP_WAIT};
      3'd6:    w = '{op: UOP_BLEND,  cond: COND_NEVER,    target: STEP_WAIT};
      default: w = '{op: UOP_EMIT,   cond: COND_OUT_BUSY, target: STEP_EMIT};
    endcase
    return w;
  endfunction

  // sin(a) for a in Q30, Taylor series to x^13, rounded to Q1.15 and capped.
  // Elaboration time only.
  function automatic logic [SINE_W-1:0] sine_q15_of_angle(input logic [63:0] a);
    logic [63:0]        a2;
    logic [63:0]        t;
    logic signed [65:0] sum;
    logic [63:0]        r;
    a2  = (a * a) >> 30;
    t   = a;
    sum = $signed({2'b00, a});
    t   = ((t * a2) >> 30) / 64'd6;
    sum = sum - $signed({2'b00, t});
    t   = ((t * a2) >> 30) / 64'd20;
    sum = sum + $signed({2'b00, t});
    t   = ((t * a2) >> 30) / 64'd42;
    sum = sum - $signed({2'b00, t});
    t   = ((t * a2) >> 30) / 64'd72;
    sum = sum + $signed({2'b00, t});
    t   = ((t * a2) >> 30) / 64'd110;
    sum = sum - $signed({2'b00, t});
    t   = ((t * a2) >> 30) / 64'd156;
    sum = sum + $signed({2'b00, t});
    if (sum < 0) begin
      sum = '0;
    end
    r = (sum[63:0] * 64'd32768 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[SINE_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/sine_alpha_fade_generator.sv @@
// Sine envelope brightness generator driven by a microcoded sequencer.
//
// Usage:
//  - s_axis carries one request per item: tuser[0] = action (0 advance one
//    tick, 1 load phase counter), tdata[16:0] = counter_value.
//  - m_axis returns one result per request: tdata[7:0] = level,
//    tdata[24:8] = phase_count, tuser[0] = finished.
//  - cfg channel writes level_max (0), level_min (1), cycle_length (2) and
//    fade_mode (3); always ready, write only while the block is idle.
//  - Sequencing: a tick that recomputes the level runs through decode,
//    17 divider steps, index, table read, multiply, blend and emit;
//    loads and finished fade ticks skip from decode to emit. The next
//    request is taken only after emit. The restoring divider sets the rate.
//  - Result register: the next request is taken while a result still waits
//    on m_axis; the sequencer holds in its emit step only if that register
//    is still occupied when the new result is ready.
//  - Reset: configuration returns to max 255, min 0, length 60, flash mode;
//    phase counter and level clear to zero, no result pending.
//  - Stall: m_axis_tready low holds tvalid and tdata stable.
`default_nettype none

module sine_alpha_fade_generator
  import safg_pkg::*;
#(
  parameter int unsigned SineEntries = SINE_TABLE_ENTRIES,
  parameter int unsigned CounterBits = COUNTER_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [23:0]         s_axis_tdata,   // [16:0] counter_value
  input  wire logic [0:0]          s_axis_tuser,   // [0] action
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [31:0]              m_axis_tdata,   // [7:0] level, [24:8] phase_count
  output logic [0:0]               m_axis_tuser,   // [0] finished
  // configuration writes
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [CFG_W-1:0]    cfg_data_i
);

  // Derived sizes
  localparam int unsigned CntW  = CounterBits;
  localparam int unsigned CmpW  = (CntW + 1 > PHASE_W) ? CntW + 1 : PHASE_W;
  localparam int unsigned NumW  = CntW + 16;
  localparam int unsigned IdxW  = $clog2(SineEntries + 1);
  localparam int unsigned HnW   = PHASE_W + IdxW;
  localparam int unsigned ProdW = 26;  // 9b signed diff * 17b signed sine

  // Quarter-wave sine table, built at elaboration
  logic [SINE_W-1:0] sine_rom [SineEntries+1];

  for (genvar gi = 0; gi <= SineEntries; gi++) begin : g_rom
    localparam logic [63:0] Angle = (HALF_PI_Q30 * 64'(gi)) / SineEntries;
    localparam logic [SINE_W-1:0] Sample = sine_q15_of_angle(Angle);
    assign sine_rom[gi] = Sample;
  end

  // Configuration registers
  logic [LEVEL_W-1:0] level_max_q, level_min_q;
  logic [LEN_W-1:0]   cycle_len_q;
  fade_mode_e         fade_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_max_q <= LEVEL_MAX_RST;
      level_min_q <= LEVEL_MIN_RST;
      cycle_len_q <= CYCLE_LEN_RST;
      fade_mode_q <= MODE_FLASH;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LEVEL_MAX: level_max_q <= cfg_data_i[LEVEL_W-1:0];
        REG_LEVEL_MIN: level_min_q <= cfg_data_i[LEVEL_W-1:0];
        REG_CYCLE_LEN: cycle_len_q <= cfg_data_i[LEN_W-1:0];
        REG_FADE_MODE: fade_mode_q <= fade_mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  step_t                  step_q, step_d;
  logic                   act_q, act_d;
  logic [PHASE_W-1:0]     value_q, value_d;
  logic [CntW-1:0]        pc_q, pc_d;
  logic [LEVEL_W-1:0]     level_q, level_d;
  logic                   done_q, done_d;
  logic [LEN_W-1:0]       rem_q, rem_d;
  logic [PHASE_W-1:0]     quo_q, quo_d;
  logic [DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [SINE_W-1:0]      sine_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic                   out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0]     out_level_q, out_level_d;
  logic [PHASE_W-1:0]     out_phase_q, out_phase_d;
  logic                   out_done_q, out_done_d;

  ucode_t uword;
  logic   cond_hit;

  // Datapath helpers
  logic [LEN_W-1:0]       len;
  logic                   is_flash, is_fade_out;
  logic [CmpW-1:0]        pc_ext, pc_inc, len_ext;
  logic                   fade_stop, skip_now;
  logic [CntW-1:0]        pc_next;
  logic [NumW-1:0]        num;
  logic [PHASE_W-1:0]     trial, trial_sub;
  logic                   fits;
  logic [PHASE_W-1:0]     hf;
  logic [HnW-1:0]         idx_wide;
  logic [LEVEL_W-1:0]     blend_from, blend_to;
  logic signed [8:0]      diff;
  logic signed [ProdW-1:0] blend_sum;

  always_comb begin
    // cycle_length 0 acts as 1
    len         = (cycle_len_q == '0) ? LEN_W'(1) : cycle_len_q;
    is_flash    = fade_mode_q[1];
    is_fade_out = (fade_mode_q == MODE_FADE_OUT);
    pc_ext      = CmpW'(pc_q);
    len_ext     = CmpW'(len);
    pc_inc      = pc_ext + CmpW'(1);  // unwrapped increment
    fade_stop   = pc_ext > len_ext;
    skip_now    = act_q || (!is_flash && fade_stop);

    if (act_q) begin
      pc_next = CntW'(value_q);
    end else if (!is_flash) begin
      pc_next = CntW'(pc_inc);
    end else if (pc_inc > len_ext) begin
      pc_next = '0;
    end else begin
      pc_next = CntW'(pc_inc);
    end

    // phase numerator: count * 65536 (flash) or count * 32768 (fades)
    num = is_flash ? (NumW'(pc_next) << 16) : (NumW'(pc_next) << 15);

    // restoring divider step; quotient bits shift into quo_q from the right
    trial     = {rem_q, quo_q[PHASE_W-1]};
    fits      = trial >= PHASE_W'(len);
    trial_sub = trial - PHASE_W'(len);

    // fold onto the quarter wave, scale to table index
    hf       = (quo_q > PHASE_W'(32768)) ? (PHASE_W'(65536) - quo_q) : quo_q;
    idx_wide = HnW'(hf) * HnW'(SineEntries);

    // blend = from + (to - from) * s / 32768, truncated
    blend_from = is_fade_out ? level_max_q : level_min_q;
    blend_to   = is_fade_out ? level_min_q : level_max_q;
    diff       = $signed({1'b0, blend_to}) - $signed({1'b0, blend_from});
    blend_sum  = $signed({3'b000, blend_from, 15'd0}) + prod_q;
  end

  // Sequencer: fetch control word, evaluate jump condition
  always_comb begin
    uword = safg_ucode(step_q);
    unique case (uword.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_NO_INPUT: cond_hit = !s_axis_tvalid;
      COND_SKIP:     cond_hit = skip_now;
      COND_DIV_MORE: cond_hit = (div_cnt_q != '0);
      COND_OUT_BUSY: cond_hit = out_valid_q && !m_axis_tready;
      default:       cond_hit = 1'b0;
    endcase
    step_d = cond_hit ? uword.target : step_t'(step_q + step_t'(1));
  end

  assign s_axis_tready = (uword.op == UOP_WAIT);

  // Datapath control
  always_comb begin
    act_d       = act_q;
    value_d     = value_q;
    pc_d        = pc_q;
    level_d     = level_q;
    done_d      = done_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_cnt_d   = div_cnt_q;
    idx_d       = idx_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_level_d = out_level_q;
    out_phase_d = out_phase_q;
    out_done_d  = out_done_q;

    unique case (uword.op)
      UOP_WAIT: begin
        if (s_axis_tvalid) begin
          act_d   = (action_e'(s_axis_tuser[0]) == ACT_LOAD);
          value_d = s_axis_tdata[PHASE_W-1:0];
        end
      end
      UOP_DECODE: begin
        done_d = !act_q && !is_flash && fade_stop;
        if (!done_d) begin
          pc_d = pc_next;
        end
        // quotient fits 17 bits, so the high part is already below len
        rem_d     = LEN_W'(num >> PHASE_W);
        quo_d     = num[PHASE_W-1:0];
        div_cnt_d = DIV_CNT_W'(DIV_STEPS - 1);
      end
      UOP_DIV: begin
        rem_d     = fits ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
        quo_d     = {quo_q[PHASE_W-2:0], fits};
        div_cnt_d = div_cnt_q - DIV_CNT_W'(1);
      end
      UOP_INDEX: begin
        idx_d = IdxW'(idx_wide >> 15);
      end
      UOP_ROM: ;  // sine_q loads below
      UOP_MUL: begin
        prod_d = ProdW'(diff) * ProdW'($signed({1'b0, sine_q}));
      end
      UOP_BLEND: begin
        level_d = blend_sum[22:15];
      end
      UOP_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_level_d = level_q;
          out_phase_d = PHASE_W'(pc_q);
          out_done_d  = done_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_WAIT;
      pc_q        <= '0;
      level_q     <= '0;
      done_q      <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      pc_q        <= pc_d;
      level_q     <= level_d;
      done_q      <= done_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    value_q     <= value_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    idx_q       <= idx_d;
    prod_q      <= prod_d;
    out_level_q <= out_level_d;
    out_phase_q <= out_phase_d;
    out_done_q  <= out_done_d;
  end

  // Registered table read
  always_ff @(posedge clk_i) begin
    if (uword.op == UOP_ROM) begin
      sine_q <= sine_rom[idx_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_phase_q, out_level_q};
  assign m_axis_tuser  = out_done_q;

endmodule

`default_nettype wire

@@ tb/sv/sine_alpha_fade_generator_tb.sv @@
// Self-checking testbench for the sine fade / flash brightness generator.
`default_nettype none

module sine_alpha_fade_generator_tb;
  import safg_pkg::*;

  // Quarter-wave table size and pi/2 in Q30, used to rebuild the sine samples.
  localparam int unsigned LUT_N           = 1024;
  localparam longint unsigned RIGHT_ANGLE_Q30 = 64'd1686629713;
  localparam int unsigned RANDOM_ITEMS    = 550;
  localparam int unsigned DRAIN_CYCLES    = 40;   // longer than a recomputing tick takes

  // One result as the block reports it.
  typedef struct packed {
    logic [7:0]  level;
    logic [16:0] phase;
    logic        fin;
  } fade_result_t;

  // One line of the directed plan: either a register write or a request.
  // Where the outcome is obvious by hand it is typed in; otherwise the
  // envelope predictor supplies it.
  typedef struct {
    bit           is_cfg;
    cfg_reg_e     reg_sel;
    logic [15:0]  reg_val;
    action_e      act;
    logic [16:0]  cval;
    bit           typed;
    fade_result_t want;
  } plan_row_t;

  // Receiver back-pressure styles, picked anew when the cycle counter's low byte wraps.
  typedef enum logic [1:0] {
    RX_OPEN,     // never stalls
    RX_COIN,     // ready half the time
    RX_STRIDE,   // ready when the low two bits of the cycle counter are both set
    RX_SPARSE    // rare random stalls
  } rx_style_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [16:0] counter_value
  logic [0:0]  s_axis_tuser  = '0;   // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [7:0] level, [24:8] phase_count
  logic [0:0]  m_axis_tuser;         // [0] finished
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;

  sine_alpha_fade_generator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------
  // Predictor state: shadow registers, phase counter, level, sine table
  // ---------------------------------------------------------------------
  logic [7:0]   cfg_max  = 8'd255;
  logic [7:0]   cfg_min  = 8'd0;
  logic [15:0]  cfg_len  = 16'd60;
  fade_mode_e   cfg_mode = MODE_FLASH;
  logic [16:0]  env_cnt  = '0;
  logic [7:0]   env_level = '0;
  logic [15:0]  sine_lut [0:LUT_N];

  fade_result_t fade_q[$];   // results still owed by the block
  plan_row_t    plan[$];

  int errors     = 0;
  int n_items    = 0;
  int n_loads    = 0;
  int n_checked  = 0;
  int n_finished = 0;
  int n_settings = 0;

  // Q1.15 sample of sin(pi/2 * i / N), Taylor series to x^13 in Q30,
  // rounded to nearest and capped just below one.
  function automatic logic [15:0] quarter_sine(int unsigned i);
    longint unsigned ang, ang2, term, r;
    longint          sum;
    int              k;
    ang  = (RIGHT_ANGLE_Q30 * i) / LUT_N;
    ang2 = (ang * ang) >> 30;
    term = ang;
    sum  = longint'(ang);
    for (k = 1; k <= 6; k++) begin
      term = ((term * ang2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= longint'(term);
      else            sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    r = ($unsigned(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) r = 64'd32767;
    return r[15:0];
  endfunction

  // Table lookup for phase h, where 65536 is a half turn.
  function automatic logic [15:0] sine_at(logic [63:0] h);
    logic [63:0] idx;
    if (h > 64'd65536) h = 64'd65536;
    if (h > 64'd32768) h = 64'd65536 - h;
    idx = (h * LUT_N) >> 15;
    if (idx > LUT_N) idx = LUT_N;
    return sine_lut[idx[10:0]];
  endfunction

  // Linear blend between two levels weighted by a Q1.15 sine, truncated.
  function automatic logic [7:0] mix(logic [7:0] from_lvl, logic [7:0] to_lvl,
                                     logic [15:0] s);
    logic [63:0] acc;
    acc = (64'(from_lvl) * (64'd32768 - 64'(s)) + 64'(to_lvl) * 64'(s)) >> 15;
    return acc[7:0];
  endfunction

  // Advance the shadow envelope by one request and return what the block
  // must report for it.
  function automatic fade_result_t envelope_step(action_e act, logic [16:0] cval);
    fade_result_t r;
    logic [63:0]  len, nxt, h;
    logic [15:0]  s;
    logic         done;
    len  = (cfg_len == 16'd0) ? 64'd1 : 64'(cfg_len);
    done = 1'b0;
    if (act == ACT_LOAD) begin
      env_cnt = cval;               // level untouched, never finished
    end else if (cfg_mode == MODE_FADE_IN || cfg_mode == MODE_FADE_OUT) begin
      if (64'(env_cnt) > len) begin
        done = 1'b1;                // fade over: counter and level frozen
      end else begin
        env_cnt = env_cnt + 17'd1;
        h = (64'(env_cnt) * 64'd32768) / len;
        s = sine_at(h);
        env_level = (cfg_mode == MODE_FADE_IN) ? mix(cfg_min, cfg_max, s)
                                               : mix(cfg_max, cfg_min, s);
      end
    end else begin
      // flash (both encodings): wrap on the unwrapped count, |sin| envelope
      nxt = 64'(env_cnt) + 64'd1;
      if (nxt > len) nxt = 64'd0;
      env_cnt = nxt[16:0];
      h = (64'(env_cnt) * 64'd65536) / len;
      s = sine_at(h);
      env_level = mix(cfg_min, cfg_max, s);
    end
    r.level = env_level;
    r.phase = env_cnt;
    r.fin   = done;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Directed plan builders
  // ---------------------------------------------------------------------
  function automatic void plan_cfg(cfg_reg_e sel, logic [15:0] val);
    plan_row_t row;
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    row.act     = ACT_ADVANCE;
    row.cval    = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    plan.push_back(row);
  endfunction

  // typed = 0: outcome comes from the predictor; the level/phase/fin
  // arguments are then ignored.
  function automatic void plan_req(action_e act, logic [16:0] cval, bit typed,
                                   logic [7:0] lvl, logic [16:0] ph, logic fin);
    plan_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_sel = REG_LEVEL_MAX;
    row.reg_val = '0;
    row.act     = act;
    row.cval    = cval;
    row.typed   = typed;
    row.want    = '{level: lvl, phase: ph, fin: fin};
    plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------
  // Bus drivers
  // ---------------------------------------------------------------------

  // Present one request and hold it until taken. tvalid is left high; the
  // caller drops it when a gap follows.
  task automatic send_req(action_e act, logic [16:0] cval, bit typed,
                          fade_result_t want);
    fade_result_t due;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, cval};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    due = envelope_step(act, cval);
    if (typed) due = want;
    fade_q.push_back(due);
    n_items++;
    if (act == ACT_LOAD) n_loads++;
  endtask

  // Register write; cfg_valid_i stays high so back-to-back writes need no
  // low cycle in between. The caller lowers it after the last write.
  task automatic write_reg(cfg_reg_e sel, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (sel)
      REG_LEVEL_MAX: cfg_max  = val[7:0];
      REG_LEVEL_MIN: cfg_min  = val[7:0];
      REG_CYCLE_LEN: cfg_len  = val;
      REG_FADE_MODE: cfg_mode = fade_mode_e'(val[1:0]);
      default: ;
    endcase
  endtask

  // Drop tvalid and idle for a number of cycles (nothing when zero).
  task automatic idle_for(int unsigned cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Hold off until the block has returned every owed result.
  task automatic wait_drained();
    while (fade_q.size() != 0) @(posedge clk_i);
  endtask

  // Extremes are favored for both level registers.
  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'd255;
      default: return 16'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly short cycles so fades finish and flashes wrap often; now and
  // then zero (treated as one) or the full 16-bit length.
  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd65535;
      2, 3:    return 16'($urandom_range(1, 3));
      4, 5, 6, 7: return 16'($urandom_range(4, 40));
      default: return 16'($urandom_range(41, 300));
    endcase
  endfunction

  // Load values cluster around the cycle length, where the fade end and the
  // flash wrap sit; the rest hit zero, the top of range and all 17 bits.
  function automatic logic [16:0] pick_load();
    int near;
    near = (cfg_len == 16'd0) ? 1 : int'(cfg_len);
    case ($urandom_range(0, 5))
      0:       return 17'd0;
      1:       return 17'd65536;
      2:       return 17'($urandom_range(0, 131071));
      default: begin
        near = near + int'($urandom_range(0, 4)) - 2;
        return (near < 0) ? 17'd0 : 17'(near);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Clock, reset and receiver back-pressure
  // ---------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  rx_style_e    rx_style = RX_OPEN;
  logic [15:0]  rx_cyc   = '0;

  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 16'd1;
    if (rx_cyc[7:0] == 8'd0) rx_style <= rx_style_e'($urandom_range(0, 3));
    case (rx_style)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_STRIDE: m_axis_tready <= (rx_cyc[1:0] == 2'd3);
      default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // ---------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    fade_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (fade_q.size() == 0) begin
        $display("%0t: unexpected result: level %0d phase %0d finished %0b",
                 $time, m_axis_tdata[7:0], m_axis_tdata[24:8], m_axis_tuser[0]);
        errors++;
      end else begin
        want = fade_q.pop_front();
        n_checked++;
        if (want.fin) n_finished++;
        if (m_axis_tdata[7:0] !== want.level) begin
          $display("%0t: level mismatch: expected %0d, actual %0d",
                   $time, want.level, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[24:8] !== want.phase) begin
          $display("%0t: phase_count mismatch: expected %0d, actual %0d",
                   $time, want.phase, m_axis_tdata[24:8]);
          errors++;
        end
        if (m_axis_tuser[0] !== want.fin) begin
          $display("%0t: finished mismatch: expected %0b, actual %0b",
                   $time, want.fin, m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  // Generous bound: about ten times the slowest legal run.
  initial begin
    #3000000;
    $display("%0t: timeout with %0d results outstanding", $time, fade_q.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    int          i;
    int unsigned pause, phase_len, burst, gap, b, sent;
    action_e     act;

    for (i = 0; i <= int'(LUT_N); i++) sine_lut[i[10:0]] = quarter_sine(i);

    // Directed plan. Reset state: flash, length 60, max 255, min 0,
    // counter 0, level 0.
    plan_req(ACT_LOAD, 17'd0,      1, 8'd0,   17'd0,      1'b0);
    plan_req(ACT_LOAD, 17'd65536,  1, 8'd0,   17'd65536,  1'b0);
    // flash from a counter past the length wraps to zero, sine zero -> min
    plan_req(ACT_ADVANCE, 17'd0,   1, 8'd0,   17'd0,      1'b0);
    plan_req(ACT_ADVANCE, 17'd0,   0, 8'd0,   17'd0,      1'b0);
    // flash peak at half the length: table top entry, capped sample
    plan_req(ACT_LOAD, 17'd29,     0, 8'd0,   17'd0,      1'b0);
    plan_req(ACT_ADVANCE, 17'd0,   1, 8'd254, 17'd30,     1'b0);
    // all 17 counter bits set, then the flash wrap on the unwrapped value
    plan_req(ACT_LOAD, 17'h1FFFF,  1, 8'd254, 17'h1FFFF,  1'b0);
    plan_req(ACT_ADVANCE, 17'd0,   1, 8'd0,   17'd0,      1'b0);
    // fade-in reaches the top at the cycle length
    plan_cfg(REG_FADE_MODE, 16'(MODE_FADE_IN));
    plan_req(ACT_LOAD, 17'd59,     1, 8'd0,   17'd59,     1'b0);
    plan_req(ACT_ADVANCE, 17'd0,   1, 8'd254, 17'd60,     1'b0);
    // fade-out reaches the bottom, then freezes once past the length
    plan_cfg(REG_FADE_MODE, 16'(MODE_FADE_OUT));
    plan_req(ACT_LOAD, 17'd59,     1, 8'd254, 17'd59,     1'b0);
    plan_req(ACT_ADVANCE, 17'd0,   1, 8'd0,   17'd60,     1'b0);
    plan_req(ACT_LOAD, 17'd65536,  1, 8'd0,   17'd65536,  1'b0);
    plan_req(ACT_ADVANCE, 17'd0,   1, 8'd0,   17'd65536,  1'b1);
    // mode three acts as flash; a zero length acts as one
    plan_cfg(REG_FADE_MODE, 16'(MODE_FLASH_B));
    plan_cfg(REG_CYCLE_LEN, 16'd0);
    plan_cfg(REG_LEVEL_MAX, 16'd200);
    plan_cfg(REG_LEVEL_MIN, 16'd50);
    plan_req(ACT_LOAD, 17'd0,      1, 8'd0,   17'd0,      1'b0);
    plan_req(ACT_ADVANCE, 17'd0,   1, 8'd50,  17'd1,      1'b0);
    plan_req(ACT_ADVANCE, 17'd0,   1, 8'd50,  17'd0,      1'b0);
    // min above max: the envelope still runs from min toward max
    plan_cfg(REG_LEVEL_MAX, 16'd0);
    plan_cfg(REG_LEVEL_MIN, 16'd255);
    plan_cfg(REG_CYCLE_LEN, 16'd2);
    plan_req(ACT_ADVANCE, 17'd0,   1, 8'd0,   17'd1,      1'b0);
    plan_req(ACT_ADVANCE, 17'd0,   1, 8'd255, 17'd2,      1'b0);
    // longest cycle: fade-out steps to 65536 then finishes
    plan_cfg(REG_LEVEL_MAX, 16'd255);
    plan_cfg(REG_LEVEL_MIN, 16'd0);
    plan_cfg(REG_CYCLE_LEN, 16'd65535);
    plan_cfg(REG_FADE_MODE, 16'(MODE_FADE_OUT));
    plan_req(ACT_LOAD, 17'd65535,  1, 8'd255, 17'd65535,  1'b0);
    plan_req(ACT_ADVANCE, 17'd0,   1, 8'd0,   17'd65536,  1'b0);
    plan_req(ACT_ADVANCE, 17'd0,   1, 8'd0,   17'd65536,  1'b1);
    // longest cycle in flash: end of half period, then wrap
    plan_cfg(REG_FADE_MODE, 16'(MODE_FLASH));
    plan_req(ACT_LOAD, 17'd65534,  1, 8'd0,   17'd65534,  1'b0);
    plan_req(ACT_ADVANCE, 17'd0,   1, 8'd0,   17'd65535,  1'b0);
    plan_req(ACT_ADVANCE, 17'd0,   1, 8'd0,   17'd0,      1'b0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed plan. Register writes only happen once every owed
    // result is back, so each write block doubles as a full drain.
    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        write_reg(plan[i].reg_sel, plan[i].reg_val);
        if (i + 1 == plan.size() || !plan[i + 1].is_cfg) begin
          cfg_valid_i <= 1'b0;
          n_settings++;
        end
      end else begin
        send_req(plan[i].act, plan[i].cval, plan[i].typed, plan[i].want);
        pause = $urandom_range(0, 3);
        if ((i + 1 == plan.size() || plan[i + 1].is_cfg) && pause == 0) pause = 1;
        idle_for(pause);
      end
    end

    // Random phases: drain, rewrite every register, then a run of requests
    // in bursts. Gaps span the whole tick latency so they land on every
    // sequencer step; some bursts run back to back with no gap at all.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      write_reg(REG_LEVEL_MAX, pick_level());
      write_reg(REG_LEVEL_MIN, pick_level());
      write_reg(REG_CYCLE_LEN, pick_length());
      write_reg(REG_FADE_MODE, 16'($urandom_range(0, 3)));
      cfg_valid_i <= 1'b0;
      n_settings++;

      phase_len = $urandom_range(15, 60);
      while (phase_len > 0) begin
        burst = $urandom_range(1, 8);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        for (b = 0; b < burst && phase_len > 0; b++) begin
          // mostly ticks; loads keep reopening finished fades
          act = ($urandom_range(0, 4) == 0) ? ACT_LOAD : ACT_ADVANCE;
          send_req(act, (act == ACT_LOAD) ? pick_load() : 17'($urandom_range(0, 131071)),
                   1'b0, '0);
          phase_len--;
          sent++;
          pause = (b == burst - 1) ? gap : 0;
          if (phase_len == 0 && pause == 0) pause = 1;
          idle_for(pause);
        end
      end
    end

    // Everything sent: wait for the last results, then watch for strays.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests (%0d loads) across %0d register settings.",
             n_items, n_loads, n_settings);
    $display("Checked %0d results, %0d of them finished fade ticks; %0d errors.",
             n_checked, n_finished, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
